FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the percentile block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWP_ASSERT_IMP(lbl, ante, cons, msg)
`define SWP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/swp_pkg.sv
// Package: shared constants, opcodes and control types of the percentile block.
package swp_pkg;

  localparam int unsigned WINDOW_DEF      = 8192;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  localparam int unsigned OP_W        = 1;
  localparam int unsigned SMP_IN_W    = 32;
  localparam int unsigned PCT_W       = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_OUT_W   = 14;
  localparam int unsigned TENTHS_FULL = 1000;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Controls from the sequencer to the scan accumulator.
  typedef struct packed {
    logic clr_cnt;
    logic clr_max;
    logic acc;
    logic upd_max;
  } scan_ctrl_t;

endpackage

FILE: sv/swp_if.sv
// Interfaces: input word channel and result word channel.
interface swp_in_if;
  import swp_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SMP_IN_W-1:0] sample;
  logic [PCT_W-1:0]    percentile_tenths;

  modport source (output valid, operation, sample, percentile_tenths, input ready);
  modport sink   (input valid, operation, sample, percentile_tenths, output ready);
endinterface

interface swp_out_if;
  import swp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     percentile_value;
  logic [VAL_W-1:0]     max_value;
  logic [CNT_OUT_W-1:0] sample_count;

  modport source (output valid, percentile_value, max_value, sample_count, input ready);
  modport sink   (input valid, percentile_value, max_value, sample_count, output ready);
endinterface

FILE: sv/swp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/swp_kdiv.sv
// Rank unit: k = tenths * n1 / 1000 as a registered multiply, then a reciprocal multiply.
module swp_kdiv #(
  parameter int unsigned CNT_W  = 14,
  parameter int unsigned PROD_W = swp_pkg::PCT_W + CNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [swp_pkg::PCT_W-1:0] tenths,
  input  logic [CNT_W-1:0]         n1,
  output logic                     busy,
  output logic [PROD_W-1:0]        quotient
);
  import swp_pkg::*;

  // floor(p / 1000) == (p * RECIP) >> SHIFT for every p below 2**PROD_W:
  // RECIP * 1000 - 2**SHIFT stays under 1000, which is below 2**(SHIFT - PROD_W).
  localparam int unsigned        SHIFT   = PROD_W + 10;
  localparam int unsigned        RECIP_W = PROD_W + 1;
  localparam int unsigned        FULL_W  = PROD_W + RECIP_W;
  localparam longint unsigned    RECIP   = ((64'd1 << SHIFT) + TENTHS_FULL - 1) / TENTHS_FULL;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic              busy_r, busy_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [FULL_W-1:0] scaled;

  assign scaled = {{RECIP_W{1'b0}}, prod_r} * {{PROD_W{1'b0}}, RECIP_C};

  // Busy for the one cycle between the product and the quotient.
  always_comb begin
    busy_nxt = start;
    prod_nxt = prod_r;
    quo_nxt  = quo_r;
    if (start) begin
      prod_nxt = PROD_W'(PROD_W'(tenths) * PROD_W'(n1));
    end else if (busy_r) begin
      quo_nxt = PROD_W'(scaled >> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: sv/swp_scan.sv
// Scan accumulator: counts samples under the current prefix with the probed bit clear, tracks max.
module swp_scan #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned CNT_W       = 14
) (
  input  logic                        clk,
  input  swp_pkg::scan_ctrl_t         ctrl,
  input  logic [SAMPLE_BITS-1:0]      rd_data,
  input  logic [SAMPLE_BITS-1:0]      prefix,
  input  logic [SAMPLE_BITS-1:0]      hi_mask,
  input  logic [SAMPLE_BITS-1:0]      bit_sel,
  output logic [CNT_W-1:0]            zero_cnt,
  output logic [SAMPLE_BITS-1:0]      max_val
);
  import swp_pkg::*;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                   hit;

  assign hit = (((rd_data ^ prefix) & hi_mask) == '0) && ((rd_data & bit_sel) == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    max_nxt = max_r;
    if (ctrl.clr_cnt) begin
      cnt_nxt = '0;
    end else if (ctrl.acc && hit) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (ctrl.clr_max) begin
      max_nxt = '0;
    end else if (ctrl.acc && ctrl.upd_max && (rd_data > max_r)) begin
      max_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    max_r <= max_nxt;
  end

  assign zero_cnt = cnt_r;
  assign max_val  = max_r;

endmodule

FILE: sv/sliding_window_percentile.sv
// Top level: sliding-window latency store with percentile and maximum queries.
// Record word: writes the RAM, no result; ready stays high.
// Query word: rank k first, then one RAM pass over the n valid samples per result bit;
//   result loaded into the output register in FIN (empty window: straight to FIN);
//   not ready meanwhile, and FIN waits while the output register holds an untaken word.
// Synchronous active-low reset clears pointer, count, sequencer and output valid; RAM kept.
`include "assert_macros.svh"

module sliding_window_percentile #(
  parameter int unsigned WINDOW      = swp_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swp_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swp_in_if.sink     in_ch,
  swp_out_if.source  out_ch
);
  import swp_pkg::*;

  localparam int unsigned ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PROD_W = PCT_W + CNT_W;

  // Sequencer: DIV forms the rank k, then one SCAN/DRAIN/DECIDE round per sample bit
  // settles the answer MSB first (radix select), FIN hands it to the output register.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Window bookkeeping
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Query working registers
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic [SAMPLE_BITS-1:0] prefix_r, prefix_nxt;
  logic [SAMPLE_BITS-1:0] mask_r, mask_nxt;
  logic [SAMPLE_BITS-1:0] bsel_r, bsel_nxt;
  logic                   first_r, first_nxt;
  logic                   empty_r, empty_nxt;
  logic                   rd_v_r;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]     out_pct_r, out_pct_nxt;
  logic [VAL_W-1:0]     out_max_r, out_max_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                   in_acc, rec_acc, qry_acc, out_take, fin_load, scan_last;
  logic [SAMPLE_BITS-1:0] smp_sat, rd_data, max_val;
  logic [PCT_W-1:0]       tenths_sat;
  logic [CNT_W-1:0]       zero_cnt;
  logic                   kd_start, kd_busy;
  logic [PROD_W-1:0]      kd_quo;
  logic [VAL_W-1:0]       pct_sat, max_sat;
  scan_ctrl_t             scan_ctrl;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rec_acc     = in_acc && (in_ch.operation == OP_RECORD);
  assign qry_acc     = in_acc && (in_ch.operation == OP_QUERY);
  assign out_take    = out_valid_r && out_ch.ready;
  assign fin_load    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Samples wider than the store saturate; the percentile saturates at 100.0.
  assign smp_sat    = ((in_ch.sample >> SAMPLE_BITS) != '0) ? '1 : SAMPLE_BITS'(in_ch.sample);
  assign tenths_sat = (in_ch.percentile_tenths > PCT_W'(TENTHS_FULL)) ?
                      PCT_W'(TENTHS_FULL) : in_ch.percentile_tenths;

  // Last valid entry of the window (count is nonzero whenever we scan)
  assign scan_last = (addr_r == ADDR_W'(cnt_r - 1'b1));

  // Results clip to the 32-bit output fields
  assign pct_sat = ((prefix_r >> VAL_W) != '0) ? '1 : VAL_W'(prefix_r);
  assign max_sat = ((max_val >> VAL_W) != '0) ? '1 : VAL_W'(max_val);

  assign kd_start = qry_acc && (cnt_r != '0);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    prefix_nxt    = prefix_r;
    mask_nxt      = mask_r;
    bsel_nxt      = bsel_r;
    first_nxt     = first_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    out_pct_nxt   = out_pct_r;
    out_max_nxt   = out_max_r;
    out_cnt_nxt   = out_cnt_r;

    scan_ctrl.clr_cnt = 1'b0;
    scan_ctrl.clr_max = 1'b0;
    scan_ctrl.acc     = rd_v_r;
    scan_ctrl.upd_max = first_r;

    if (rec_acc) begin
      wp_nxt = (wp_r == ADDR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
      if (cnt_r != CNT_W'(WINDOW)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (qry_acc) begin
          empty_nxt = (cnt_r == '0);
          state_nxt = (cnt_r == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (!kd_busy) begin
          k_nxt             = CNT_W'(kd_quo);
          addr_nxt          = '0;
          prefix_nxt        = '0;
          mask_nxt          = '0;
          bsel_nxt          = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
          first_nxt         = 1'b1;
          scan_ctrl.clr_cnt = 1'b1;
          scan_ctrl.clr_max = 1'b1;
          state_nxt         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last read word lands in the accumulator this cycle
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Fewer than k+1 samples with this bit clear: the answer has it set.
        if (k_r >= zero_cnt) begin
          k_nxt      = k_r - zero_cnt;
          prefix_nxt = prefix_r | bsel_r;
        end
        mask_nxt          = {1'b1, mask_r[SAMPLE_BITS-1:1]};
        bsel_nxt          = bsel_r >> 1;
        first_nxt         = 1'b0;
        addr_nxt          = '0;
        scan_ctrl.clr_cnt = 1'b1;
        state_nxt         = bsel_r[0] ? ST_FIN : ST_SCAN;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = empty_r ? '0 : pct_sat;
          out_max_nxt   = empty_r ? '0 : max_sat;
          out_cnt_nxt   = CNT_OUT_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    addr_r    <= addr_nxt;
    prefix_r  <= prefix_nxt;
    mask_r    <= mask_nxt;
    bsel_r    <= bsel_nxt;
    first_r   <= first_nxt;
    empty_r   <= empty_nxt;
    out_pct_r <= out_pct_nxt;
    out_max_r <= out_max_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  swp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (rec_acc),
    .waddr (wp_r),
    .wdata (smp_sat),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  swp_kdiv #(
    .CNT_W  (CNT_W),
    .PROD_W (PROD_W)
  ) u_kdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kd_start),
    .tenths   (tenths_sat),
    .n1       (cnt_r - 1'b1),
    .busy     (kd_busy),
    .quotient (kd_quo)
  );

  swp_scan #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_scan (
    .clk      (clk),
    .ctrl     (scan_ctrl),
    .rd_data  (rd_data),
    .prefix   (prefix_r),
    .hi_mask  (mask_r),
    .bit_sel  (bsel_r),
    .zero_cnt (zero_cnt),
    .max_val  (max_val)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.percentile_value = out_pct_r;
  assign out_ch.max_value        = out_max_r;
  assign out_ch.sample_count     = out_cnt_r;

  // Checks
  `SWP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(WINDOW), "valid count above window")
  `SWP_ASSERT_IMP(a_wp_tracks_cnt, cnt_r != CNT_W'(WINDOW), CNT_W'(wp_r) == cnt_r, "pointer off count")
  `SWP_ASSERT_IMP(a_rank_in_window, state_r == ST_SCAN, k_r < cnt_r, "rank outside window")
  `SWP_ASSERT_NXT(a_fin_loads, fin_load, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sliding-window percentile block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swp_pkg::*;

  localparam int unsigned WIN         = WINDOW_DEF;
  localparam int unsigned PTR_W       = $clog2(WINDOW_DEF);
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned TAIL_RECORDS = 80;      // records in the final no-idle stretch
  localparam int unsigned HOLD_CYCLES = 3000;     // long receiver hold-off
  localparam int unsigned HOLD_AFTER  = 8;        // results seen before the hold-off
  localparam int unsigned DRAIN_WAIT  = 64;       // extra cycles at the end
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  // One input word and one result word, at the block's widths.
  typedef struct packed {
    op_t                 op;
    logic [SMP_IN_W-1:0] sample;
    logic [PCT_W-1:0]    tenths;
  } stat_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]     pct;
    logic [VAL_W-1:0]     peak;
    logic [CNT_OUT_W-1:0] count;
  } stat_result_t;

  logic clk;
  logic rst_n;

  swp_in_if  in_ch ();
  swp_out_if out_ch ();

  sliding_window_percentile dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Words waiting to be offered, and query results still owed by the block.
  stat_word_t   pending_words[$];
  stat_result_t stats_due[$];

  // Shadow of the block's window: circular store, write pointer, fill count.
  logic [VAL_W-1:0]     window_mem [WIN];
  logic [PTR_W-1:0]     wr_ptr = '0;
  logic [CNT_OUT_W-1:0] fill_cnt = '0;

  stat_word_t  offered;                 // word currently on the input channel
  bit          word_taken = 1'b0;       // set at the edge that accepted it
  bit          quiet_tail = 1'b0;       // no idling on either side from here on
  int unsigned tail_len = 0;            // words in the final no-idle stretch
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Sender idling state.
  int unsigned tx_gap = 0;
  int unsigned tx_seg_left = 0;
  bit          tx_bursty = 1'b0;

  // Receiver idling state.
  int unsigned rx_gap = 0;
  int unsigned rx_seg_left = 0;
  bit          rx_bursty = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  // Queue one word for the driver.
  function automatic void add_word(op_t op, logic [SMP_IN_W-1:0] smp,
                                   logic [PCT_W-1:0] pct);
    stat_word_t w;
    w.op     = op;
    w.sample = smp;
    w.tenths = pct;
    pending_words = {pending_words, w};
  endfunction

  // Latency sample mix: small values (lots of ties), full range, near the top, up to 1000.
  function automatic logic [SMP_IN_W-1:0] pick_sample();
    logic [SMP_IN_W-1:0] s;
    case ($urandom_range(0, 3))
      0: begin
        s = $urandom_range(0, 15);
      end
      1: begin
        s = $urandom;
      end
      2: begin
        s = 32'hFFFF_FFFF - $urandom_range(0, 15);
      end
      default: begin
        s = $urandom_range(0, 1000);
      end
    endcase
    return s;
  endfunction

  // Percentile mix: above full scale, the exact extremes, and in-range values.
  function automatic logic [PCT_W-1:0] pick_tenths();
    logic [PCT_W-1:0] t;
    case ($urandom_range(0, 4))
      0: begin
        t = PCT_W'($urandom_range(TENTHS_FULL + 1, (1 << PCT_W) - 1));
      end
      1: begin
        case ($urandom_range(0, 2))
          0:       t = '0;
          1:       t = PCT_W'(TENTHS_FULL - 1);
          default: t = PCT_W'(TENTHS_FULL);
        endcase
      end
      default: begin
        t = PCT_W'($urandom_range(0, TENTHS_FULL));
      end
    endcase
    return t;
  endfunction

  // Window model: a record updates the store; a query owes one result word
  // holding the order statistic, the window maximum and the fill count.
  function automatic void track_word(stat_word_t w);
    stat_result_t r;
    int unsigned  sorted_vals[];
    int unsigned  lvl;
    int unsigned  rank;
    if (w.op == OP_RECORD) begin
      window_mem[wr_ptr] = w.sample;
      wr_ptr = wr_ptr + 1'b1;           // wraps at the window size
      if (fill_cnt < WIN) fill_cnt = fill_cnt + 1'b1;
    end else begin
      r = '0;                           // empty window answers all zeros
      if (fill_cnt != 0) begin
        lvl  = (w.tenths > TENTHS_FULL) ? TENTHS_FULL : 32'(w.tenths);
        rank = (lvl * (fill_cnt - 1)) / TENTHS_FULL;
        sorted_vals = new[fill_cnt];
        for (int unsigned i = 0; i < fill_cnt; i++) begin
          sorted_vals[i] = window_mem[PTR_W'(i)];
          if (window_mem[PTR_W'(i)] > r.peak) r.peak = window_mem[PTR_W'(i)];
        end
        sorted_vals.sort();
        r.pct   = sorted_vals[rank];
        r.count = fill_cnt;
      end
      stats_due = {stats_due, r};
    end
  endfunction

  // Acceptance: sampled at the rising edge, feeds the model.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      track_word(offered);
      word_taken = 1'b1;
    end
  end

  // Driver: changes the input channel at the falling edge. A word stays up
  // until taken; between words the sender may pause, but only inside
  // bursty segments and never in the final stretch.
  always @(negedge clk) begin
    logic       offer;
    stat_word_t w;
    offer = in_ch.valid;
    w     = offered;
    if (tx_seg_left == 0) begin
      tx_seg_left = $urandom_range(64, 256);
      tx_bursty   = ($urandom_range(0, 3) != 0);
    end else begin
      tx_seg_left--;
    end
    if (rst_n && (word_taken || !in_ch.valid)) begin
      word_taken = 1'b0;
      offer      = 1'b0;
      if (pending_words.size() <= tail_len) quiet_tail = 1'b1;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_words.size() != 0) begin
        if (!quiet_tail && tx_bursty && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 11);
        end else begin
          w     = pending_words.pop_front();
          offer = 1'b1;
        end
      end
    end
    offered                    = w;
    in_ch.valid               <= offer;
    in_ch.operation           <= w.op;
    in_ch.sample              <= w.sample;
    in_ch.percentile_tenths   <= w.tenths;
  end

  // Receiver: random stall bursts, plus one long hold-off once a few results
  // have come, so the output backs up and the block stops taking words.
  always @(negedge clk) begin
    logic take;
    take = 1'b1;
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(64, 256);
      rx_bursty   = ($urandom_range(0, 3) != 0);
    end else begin
      rx_seg_left--;
    end
    if (!hold_used && !quiet_tail && results_seen >= HOLD_AFTER) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      take = 1'b0;
    end else if (!quiet_tail && rx_bursty && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 11);
      take   = 1'b0;
    end
    out_ch.ready <= take;
  end

  // Monitor: every result word is checked against the oldest owed result.
  always @(posedge clk) begin
    stat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        $display("%0t: result with none owed: pct=%0d max=%0d count=%0d", $time,
                 out_ch.percentile_value, out_ch.max_value, out_ch.sample_count);
        mismatches++;
      end else begin
        want = stats_due.pop_front();
        if (out_ch.percentile_value !== want.pct) begin
          $display("%0t: percentile_value expected %0d actual %0d", $time,
                   want.pct, out_ch.percentile_value);
          mismatches++;
        end
        if (out_ch.max_value !== want.peak) begin
          $display("%0t: max_value expected %0d actual %0d", $time,
                   want.peak, out_ch.max_value);
          mismatches++;
        end
        if (out_ch.sample_count !== want.count) begin
          $display("%0t: sample_count expected %0d actual %0d", $time,
                   want.count, out_ch.sample_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned fill;
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.operation         = OP_RECORD;
    in_ch.sample            = '0;
    in_ch.percentile_tenths = '0;
    out_ch.ready            = 1'b0;
    offered                 = '0;

    // Directed: empty window (one with an over-range percentile and a junk
    // sample field), then the sample extremes, ties, and percentile edges.
    add_word(OP_QUERY,  32'h0000_0000, 10'd0);
    add_word(OP_QUERY,  32'hFFFF_FFFF, 10'h3FF);
    add_word(OP_RECORD, 32'h0000_0000, 10'h3FF);   // percentile field ignored
    add_word(OP_QUERY,  32'h0000_0000, 10'd0);
    add_word(OP_QUERY,  32'h1234_5678, 10'd1000);
    add_word(OP_RECORD, 32'hFFFF_FFFF, 10'd0);
    add_word(OP_RECORD, 32'h0000_0001, 10'h2AA);
    add_word(OP_RECORD, 32'h8000_0000, 10'h155);
    add_word(OP_QUERY,  32'h0000_0000, 10'd0);
    add_word(OP_QUERY,  32'h0000_0000, 10'd500);
    add_word(OP_QUERY,  32'h0000_0000, 10'd999);
    add_word(OP_QUERY,  32'h0000_0000, 10'd1000);
    add_word(OP_QUERY,  32'hFFFF_FFFF, 10'h3FF);
    add_word(OP_RECORD, 32'h0000_0001, 10'd0);
    add_word(OP_RECORD, 32'h0000_0001, 10'd1000);
    add_word(OP_QUERY,  32'h0000_0000, 10'd333);
    add_word(OP_QUERY,  32'h0000_0000, 10'd1001);

    // Random: mostly records, roughly one query in eight. Query cost grows
    // with the window, so the window stays a few hundred deep here.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 7) == 0)
        add_word(OP_QUERY, $urandom, pick_tenths());
      else
        add_word(OP_RECORD, pick_sample(), PCT_W'($urandom_range(0, (1 << PCT_W) - 1)));
    end

    // Tail: a no-idle run of records, then two queries over the whole
    // window at the percentile extremes.
    fill = TAIL_RECORDS;
    for (int unsigned i = 0; i < fill; i++)
      add_word(OP_RECORD, pick_sample(), PCT_W'($urandom_range(0, (1 << PCT_W) - 1)));
    add_word(OP_QUERY, $urandom, 10'd1000);
    add_word(OP_QUERY, $urandom, 10'd0);
    tail_len = fill + 2;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Everything offered and taken, and every owed result returned.
    do @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || stats_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/swp_pkg.sv
sv/swp_if.sv
sv/swp_ram.sv
sv/swp_kdiv.sv
sv/swp_scan.sv
sv/sliding_window_percentile.sv
dv/testbench.sv
